// ===== sv/assert_macros.svh =====
// Assertion helpers, compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/hcr_pkg.sv =====
package hcr_pkg;

  localparam int MAX_RAMP_DEF  = 4096;
  localparam int FRAC_BITS_DEF = 14;
  localparam int ANG_BITS      = 24;
  localparam int CORDIC_ITER   = 20;
  localparam int HUE_NUM       = 1998;
  localparam int HUE_DEN       = 1000;

  localparam logic signed [15:0] MIN_RST  = -16'sd16384;
  localparam logic signed [15:0] MAX_RST  = 16'sd16384;
  localparam logic [12:0]        LEN_RST  = 13'd512;
  localparam logic               MODE_RST = 1'b1;

  typedef enum logic [1:0] {
    CFG_MIN  = 2'd0,
    CFG_MAX  = 2'd1,
    CFG_LEN  = 2'd2,
    CFG_MODE = 2'd3
  } cfg_idx_t;

  // sideband that rides along the pipeline
  typedef struct packed {
    logic       err;
    logic [7:0] grey;
  } side_t;

  // round(atan(2^-i) * 4/pi * 2^24)
  function automatic logic signed [26:0] atan_tab(input int i);
    logic signed [26:0] v;
    case (i)
      0:  v = 27'sd16777216;
      1:  v = 27'sd9904169;
      2:  v = 27'sd5233091;
      3:  v = 27'sd2656399;
      4:  v = 27'sd1333354;
      5:  v = 27'sd667327;
      6:  v = 27'sd333745;
      7:  v = 27'sd166883;
      8:  v = 27'sd83443;
      9:  v = 27'sd41721;
      10: v = 27'sd20861;
      11: v = 27'sd10430;
      12: v = 27'sd5215;
      13: v = 27'sd2608;
      14: v = 27'sd1304;
      15: v = 27'sd652;
      16: v = 27'sd326;
      17: v = 27'sd163;
      18: v = 27'sd81;
      19: v = 27'sd41;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

  // Q24 channel in [0,1] to byte: (v*255) >> 24
  function automatic logic [7:0] chan_byte(input logic [24:0] v);
    logic [32:0] t;
    t = {v, 8'b0} - {8'b0, v};
    return t[31:24];
  endfunction

endpackage

// ===== sv/height_to_color_ramp.sv =====
// height_to_color_ramp: ramp index -> interpolated Q height -> RGB bytes.
// Start to out_valid runs through stage A, stage B, the divider, stage H, the CORDIC, M, P and C.
// Throughput: one item per cycle; busy is always low, nothing can stall.
// Reset (rst_n low, synchronous): pipeline emptied, registers to defaults
// (min -1.0, max +1.0, length 512, hue mode).
`include "assert_macros.svh"

module height_to_color_ramp #(
  parameter int MAX_RAMP  = hcr_pkg::MAX_RAMP_DEF,
  parameter int FRAC_BITS = hcr_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_ramp_index,
  // results
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_range_error,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int NW  = 28;  // interpolation quotient magnitude bits
  localparam int DW  = 13;  // divisor / remainder bits
  localparam int HW  = FRAC_BITS + 2;  // in-range height bits
  localparam int XW  = 28;  // CORDIC x/y
  localparam int ZW  = 27;  // CORDIC angle
  localparam int HQB = 27;  // hue quotient bits
  localparam int SH  = hcr_pkg::ANG_BITS - FRAC_BITS;
  localparam int IT  = hcr_pkg::CORDIC_ITER;
  localparam logic signed [29:0] ONE_H = 30'sd1 <<< FRAC_BITS;
  localparam logic signed [XW-1:0] ONE_X = XW'(1) <<< hcr_pkg::ANG_BITS;
  localparam logic [24:0] ONE_Q = 25'd1 << hcr_pkg::ANG_BITS;
  // d * 1998 / 1000 = 2d - d / 500, so hue = 2d - ceil(d / 500)
  localparam int HDIV = hcr_pkg::HUE_DEN / (2 * hcr_pkg::HUE_DEN - hcr_pkg::HUE_NUM);
  // ceil(2^32 / 125): floor(x * RECIP >> 32) = floor(x / 125), exact for x < 2^25
  localparam logic [25:0] RECIP = 26'd34359739;

  // ---------------------------------------------------------------------
  // Configuration registers. Always ready; write only while idle (the block does not enforce it).
  // ---------------------------------------------------------------------
  logic signed [15:0] min_r, max_r;
  logic [12:0]        len_r;
  logic               mode_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= hcr_pkg::MIN_RST;
      max_r  <= hcr_pkg::MAX_RST;
      len_r  <= hcr_pkg::LEN_RST;
      mode_r <= hcr_pkg::MODE_RST;
    end else if (cfg_valid) begin
      unique case (hcr_pkg::cfg_idx_t'(cfg_index))
        hcr_pkg::CFG_MIN:  min_r  <= signed'(cfg_data);
        hcr_pkg::CFG_MAX:  max_r  <= signed'(cfg_data);
        hcr_pkg::CFG_LEN:  len_r  <= cfg_data[12:0];
        hcr_pkg::CFG_MODE: mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Effective divisor: length capped at MAX_RAMP; a ramp shorter than two
  // entries pins the height to min (numerator zeroed, divisor forced to 1).
  logic [DW-1:0] len_c, div_c;
  logic          short_c;

  always_comb begin
    len_c   = ({19'b0, len_r} > MAX_RAMP) ? DW'(MAX_RAMP) : len_r;
    short_c = (len_c < DW'(2));
    div_c   = short_c ? DW'(1) : len_c - DW'(1);
  end

  // ---------------------------------------------------------------------
  // Stage A: (max - min) * index
  // ---------------------------------------------------------------------
  logic               va_r;
  logic signed [29:0] prod_r;
  logic signed [16:0] diff_c;

  assign diff_c = 17'(max_r) - 17'(min_r);

  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else        va_r <= start;
    prod_r <= short_c ? 30'sd0 : 30'(diff_c * signed'({1'b0, in_ramp_index}));
  end

  // ---------------------------------------------------------------------
  // Stage B: magnitude and sign, load divider
  // ---------------------------------------------------------------------
  logic          dv_r   [NW+1];
  logic          dneg_r [NW+1];
  logic [DW-1:0] drem_r [NW+1];
  logic [NW-1:0] dwrk_r [NW+1];
  logic [29:0]   mag_c;

  assign mag_c = prod_r[29] ? 30'(-prod_r) : 30'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) dv_r[0] <= 1'b0;
    else        dv_r[0] <= va_r;
    dneg_r[0] <= prod_r[29];
    drem_r[0] <= '0;
    dwrk_r[0] <= mag_c[NW-1:0];
  end

  // Restoring divider, one quotient bit per stage, MSB first.
  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [DW:0] t_c, s_c;
    logic        ge_c;
    always_comb begin
      t_c  = {drem_r[k], dwrk_r[k][NW-1]};
      ge_c = (t_c >= {1'b0, div_c});
      s_c  = t_c - {1'b0, div_c};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[k+1] <= 1'b0;
      else        dv_r[k+1] <= dv_r[k];
      dneg_r[k+1] <= dneg_r[k];
      drem_r[k+1] <= ge_c ? s_c[DW-1:0] : t_c[DW-1:0];
      dwrk_r[k+1] <= {dwrk_r[k][NW-2:0], ge_c};
    end
  end

  // ---------------------------------------------------------------------
  // Stage H: height, range check, grey byte, CORDIC load
  // ---------------------------------------------------------------------
  logic signed [28:0] q_c;
  logic signed [29:0] h_c;
  logic               err_c;
  logic [FRAC_BITS+9:0] gsum_c;

  always_comb begin
    q_c    = dneg_r[NW] ? -signed'({1'b0, dwrk_r[NW]}) : signed'({1'b0, dwrk_r[NW]});
    h_c    = 30'(min_r) + 30'(q_c);
    err_c  = (h_c > ONE_H) || (h_c < -ONE_H);
    gsum_c = (FRAC_BITS+10)'(h_c + ONE_H) * (FRAC_BITS+10)'(255);
  end

  logic                 cv_r [IT+1];
  hcr_pkg::side_t       cs_r [IT+1];
  logic signed [XW-1:0] cx_r [IT+1];
  logic signed [XW-1:0] cy_r [IT+1];
  logic signed [ZW-1:0] cz_r [IT+1];

  always_ff @(posedge clk) begin
    if (!rst_n) cv_r[0] <= 1'b0;
    else        cv_r[0] <= dv_r[NW];
    cs_r[0].err  <= err_c;
    cs_r[0].grey <= gsum_c[FRAC_BITS+8:FRAC_BITS+1];
    cx_r[0]      <= ONE_X;
    cy_r[0]      <= XW'($signed(h_c[HW-1:0])) <<< SH;
    cz_r[0]      <= '0;
  end

  // CORDIC vectoring, one micro-rotation per stage.
  for (genvar i = 0; i < IT; i++) begin : g_cordic
    logic signed [XW-1:0] xs_c, ys_c;
    assign xs_c = cx_r[i] >>> i;
    assign ys_c = cy_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i+1] <= 1'b0;
      else        cv_r[i+1] <= cv_r[i];
      cs_r[i+1] <= cs_r[i];
      if (!cy_r[i][XW-1]) begin
        cx_r[i+1] <= cx_r[i] + ys_c;
        cy_r[i+1] <= cy_r[i] - xs_c;
        cz_r[i+1] <= cz_r[i] + hcr_pkg::atan_tab(i);
      end else begin
        cx_r[i+1] <= cx_r[i] - ys_c;
        cy_r[i+1] <= cy_r[i] + xs_c;
        cz_r[i+1] <= cz_r[i] - hcr_pkg::atan_tab(i);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage M: d = max(0, 1 - u), ceil(d / 500) numerator pre-scaled by 1/4
  // ---------------------------------------------------------------------
  logic signed [XW-1:0] d_c;
  logic [25:0]          dcl_c;
  logic [26:0]          cn_c;

  always_comb begin
    d_c   = ONE_X - XW'(cz_r[IT]);
    dcl_c = d_c[XW-1] ? 26'd0 : d_c[25:0];
    cn_c  = {1'b0, dcl_c} + 27'(HDIV - 1);
  end

  logic           mv_r;
  hcr_pkg::side_t ms_r;
  logic [25:0]    mdcl_r;
  logic [24:0]    mx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) mv_r <= 1'b0;
    else        mv_r <= cv_r[IT];
    ms_r   <= cs_r[IT];
    mdcl_r <= dcl_c;
    mx_r   <= cn_c[26:2];  // /4 here, /125 by reciprocal next
  end

  // ---------------------------------------------------------------------
  // Stage P: ceil(d / 500) by reciprocal multiply
  // ---------------------------------------------------------------------
  logic [50:0]    pq_c;
  logic           pv_r;
  hcr_pkg::side_t ps_r;
  logic [25:0]    pdcl_r;
  logic [18:0]    pcq_r;

  assign pq_c = 51'(mx_r) * 51'(RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else        pv_r <= mv_r;
    ps_r   <= ms_r;
    pdcl_r <= mdcl_r;
    pcq_r  <= pq_c[50:32];
  end

  // ---------------------------------------------------------------------
  // Stage C: hue = 2d - ceil(d/500), six-sector HSV, grey or black, output register
  // ---------------------------------------------------------------------
  logic [HQB-1:0] hq_c;
  logic [24:0]    m_c, dev_c, xt_c, r_c, g_c, b_c;
  logic [7:0]     r_nxt, g_nxt, b_nxt;
  hcr_pkg::side_t sd_c;

  always_comb begin
    hq_c  = {pdcl_r, 1'b0} - HQB'(pcq_r);
    sd_c  = ps_r;
    m_c   = hq_c[24:0];
    dev_c = (m_c >= ONE_Q) ? m_c - ONE_Q : ONE_Q - m_c;
    xt_c  = ONE_Q - dev_c;
    case (hq_c[HQB-1:24])
      3'd0:    begin r_c = ONE_Q; g_c = xt_c;  b_c = '0;    end
      3'd1:    begin r_c = xt_c;  g_c = ONE_Q; b_c = '0;    end
      3'd2:    begin r_c = '0;    g_c = ONE_Q; b_c = xt_c;  end
      3'd3:    begin r_c = '0;    g_c = xt_c;  b_c = ONE_Q; end
      3'd4:    begin r_c = xt_c;  g_c = '0;    b_c = ONE_Q; end
      default: begin r_c = ONE_Q; g_c = '0;    b_c = xt_c;  end
    endcase
    if (sd_c.err) begin
      r_nxt = '0; g_nxt = '0; b_nxt = '0;
    end else if (mode_r) begin
      r_nxt = hcr_pkg::chan_byte(r_c);
      g_nxt = hcr_pkg::chan_byte(g_c);
      b_nxt = hcr_pkg::chan_byte(b_c);
    end else begin
      r_nxt = sd_c.grey; g_nxt = sd_c.grey; b_nxt = sd_c.grey;
    end
  end

  logic       ov_r, oerr_r;
  logic [7:0] ored_r, ogrn_r, oblu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= pv_r;
    oerr_r <= sd_c.err;
    ored_r <= r_nxt;
    ogrn_r <= g_nxt;
    oblu_r <= b_nxt;
  end

  assign out_valid       = ov_r;
  assign out_range_error = oerr_r;
  assign out_red         = ored_r;
  assign out_green       = ogrn_r;
  assign out_blue        = oblu_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `ASSERT_CLK(a_err_black, out_valid && out_range_error |-> (out_red == 8'd0) && (out_green == 8'd0) && (out_blue == 8'd0), "range error with nonzero colour")
  `ASSERT_CLK(a_grey_equal, out_valid && !out_range_error && !mode_r |-> (out_red == out_green) && (out_green == out_blue), "grey channels differ")
  `ASSERT_CLK(a_hue_full, out_valid && !out_range_error && mode_r |-> (out_red == 8'hFF) || (out_green == 8'hFF) || (out_blue == 8'hFF), "hue has no full channel")
  `ASSERT_CLK(a_hue_zero, out_valid && !out_range_error && mode_r |-> (out_red == 8'd0) || (out_green == 8'd0) || (out_blue == 8'd0), "hue has no empty channel")

endmodule

// ===== test/ramp_color_checker.sv =====
module ramp_color_checker
  import hcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [11:0] in_ramp_index,
  input  logic        out_valid,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic        out_range_error,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       range_error;
  } pixel_t;

  // shadow copy of the register file
  logic signed [15:0] lo_h;
  logic signed [15:0] hi_h;
  logic [12:0]        len_r;
  logic               mode_r;

  pixel_t colors_due[$];

  function automatic longint fshr(longint v, int s);
    if (v >= 0) return v >>> s;
    return -64'sd1 - ((-64'sd1 - v) >>> s);
  endfunction

  function automatic logic [7:0] to_byte(longint v);
    longint t;
    t = (v < 0) ? 0 : v;
    if (t > (64'sd1 <<< 24)) t = 64'sd1 <<< 24;
    t = (t * 255) >>> 24;
    return t[7:0];
  endfunction

  function automatic pixel_t color_of(logic [11:0] idx);
    pixel_t p;
    longint one, h, len, x, y, z, xs, ys, d, hq, m, xt, r, g, b, q24, gv;
    longint tab[20];
    tab = '{16777216, 9904169, 5233091, 2656399, 1333354, 667327, 333745, 166883,
            83443, 41721, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41};
    one = 64'sd1 <<< 14;
    q24 = 64'sd1 <<< 24;
    p = '0;
    len = len_r;
    if (len > 4096) len = 4096;
    h = lo_h;
    if (len >= 2) h = lo_h + ((longint'(hi_h) - lo_h) * longint'(idx)) / (len - 1);
    if (h > one || h < -one) begin
      p.range_error = 1'b1;
    end else if (mode_r) begin
      x = q24;
      y = h * 1024;
      z = 0;
      for (int i = 0; i < 20; i++) begin
        xs = fshr(x, i);
        ys = fshr(y, i);
        if (y >= 0) begin
          x += ys; y -= xs; z += tab[i];
        end else begin
          x -= ys; y += xs; z -= tab[i];
        end
      end
      d = q24 - z;
      if (d < 0) d = 0;
      hq = d * 1998 / 1000;
      m = hq & ((q24 <<< 1) - 1);
      xt = q24 - ((m >= q24) ? m - q24 : q24 - m);
      case (hq >>> 24)
        0: begin r = q24; g = xt;  b = 0;   end
        1: begin r = xt;  g = q24; b = 0;   end
        2: begin r = 0;   g = q24; b = xt;  end
        3: begin r = 0;   g = xt;  b = q24; end
        4: begin r = xt;  g = 0;   b = q24; end
        default: begin r = q24; g = 0; b = xt; end
      endcase
      p.red = to_byte(r);
      p.green = to_byte(g);
      p.blue = to_byte(b);
    end else begin
      gv = ((h + one) * 255) >>> 15;
      p.red = gv[7:0];
      p.green = gv[7:0];
      p.blue = gv[7:0];
    end
    return p;
  endfunction

  assign pending = colors_due.size();

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      lo_h <= MIN_RST;
      hi_h <= MAX_RST;
      len_r <= LEN_RST;
      mode_r <= MODE_RST;
      colors_due.delete();
      fail_count <= 0;
    end else begin
      if (start && !busy) colors_due.push_back(color_of(in_ramp_index));
      if (out_valid) begin
        if (colors_due.size() == 0) begin
          $error("result with no transfer waiting");
          fail_count <= fail_count + 1;
        end else begin
          want = colors_due.pop_front();
          if (out_red !== want.red || out_green !== want.green
              || out_blue !== want.blue || out_range_error !== want.range_error)
            fail_count <= fail_count + 1;
          if (out_red !== want.red)
            $error("red: expected %0d got %0d", want.red, out_red);
          if (out_green !== want.green)
            $error("green: expected %0d got %0d", want.green, out_green);
          if (out_blue !== want.blue)
            $error("blue: expected %0d got %0d", want.blue, out_blue);
          if (out_range_error !== want.range_error)
            $error("range_error: expected %0b got %0b", want.range_error,
                   out_range_error);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MIN:  lo_h <= cfg_data;
          CFG_MAX:  hi_h <= cfg_data;
          CFG_LEN:  len_r <= cfg_data[12:0];
          CFG_MODE: mode_r <= cfg_data[0];
        endcase
      end
    end
  end
endmodule

// ===== test/tb.sv =====
module tb;
  import hcr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;  // idle cycles before giving up
  localparam int DRAIN = 100;         // extra wait once no result is pending

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [11:0] in_ramp_index;
  logic        out_valid;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_range_error;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count;
  int          pending;
  int          idle_cycles;

  height_to_color_ramp dut (.*);

  ramp_color_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: counts cycles with no transfer anywhere
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // one register write; only called while nothing is in flight
  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic setup(logic [15:0] lo, logic [15:0] hi, logic [12:0] len, logic mode);
    write_reg(CFG_MIN, lo);
    write_reg(CFG_MAX, hi);
    write_reg(CFG_LEN, {3'b0, len});
    write_reg(CFG_MODE, {15'b0, mode});
  endtask

  // present one index; a gap before it unless back_to_back
  task automatic send_index(logic [11:0] idx, bit back_to_back);
    int gap;
    if (!back_to_back) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    start <= 1'b1;
    in_ramp_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // let the pipeline empty before touching registers
  task automatic drain;
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic random_phase(int count);
    bit burst;
    burst = $urandom_range(0, 3) == 0;
    for (int i = 0; i < count; i++) begin
      // mostly within the ramp, sometimes past it to extrapolate
      if ($urandom_range(0, 4) == 0) send_index(12'($urandom()), burst);
      else send_index(12'($urandom_range(0, 600)), burst);
    end
  endtask

  initial begin
    logic [15:0] lo, hi;
    rst_n = 1'b0;
    start = 1'b0;
    in_ramp_index = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MIN;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset setting, ends of the ramp and indexes past it
    send_index(12'd0, 0);
    send_index(12'd255, 0);
    send_index(12'd511, 0);
    send_index(12'd512, 1);
    send_index(12'd4095, 1);
    drain();
    // grey mode, full-scale registers, indexes out of range
    setup(16'h8000, 16'h7fff, 13'd4096, 1'b0);
    send_index(12'd0, 1);
    send_index(12'd2047, 1);
    send_index(12'd2048, 1);
    send_index(12'd4095, 1);
    drain();
    // short ramps: length 0 and 1 give min_height
    setup(16'hc000, 16'h4000, 13'd0, 1'b1);
    send_index(12'd7, 0);
    drain();
    write_reg(CFG_LEN, 16'd1);
    send_index(12'd4095, 0);
    drain();
    // length above the ramp maximum, hue over exactly -1..1
    setup(16'hc000, 16'h4000, 13'h1fff, 1'b1);
    send_index(12'd0, 1);
    send_index(12'd2047, 1);
    send_index(12'd4095, 1);
    drain();
    write_reg(CFG_LEN, 16'd2);
    send_index(12'd0, 0);
    send_index(12'd1, 0);
    send_index(12'd2, 0);
    drain();

    // random phases over random settings; hold off fully between them
    for (int ph = 0; ph < 20; ph++) begin
      lo = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 32768) - 16384);
      hi = $urandom_range(0, 3) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 32768) - 16384);
      setup(lo, hi, 13'($urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(2, 600)),
            1'($urandom()));
      random_phase(50);
      drain();
    end
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
